// ===== sv/nwm_pkg.sv =====
package nwm_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_MONTH = 2'd1,
        ST_BAD_YEAR  = 2'd2,
        ST_NO_MATCH  = 2'd3
    } nwm_status_t;

    localparam logic [2:0]  KIND_TEENTH = 3'd0;
    localparam logic [2:0]  KIND_FIRST  = 3'd1;
    localparam logic [2:0]  KIND_LAST   = 3'd5;
    localparam logic [2:0]  WEEKDAY_MAX = 3'd6;

    localparam logic [13:0] YEAR_MIN = 14'd1400;
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // x / 100 == (x * 5243) >> 19 for every 14-bit x
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    // x / 7 == (x * 9363) >> 16 for every 11-bit x
    localparam logic [13:0] DIV7_MUL     = 14'd9363;
    localparam int          DIV7_SHIFT   = 16;

    // fields that ride along with every transaction
    typedef struct packed {
        nwm_status_t status;
        logic [2:0]  want;
        logic [2:0]  kind;
    } nwm_ctl_t;

    typedef struct packed {
        nwm_ctl_t    ctl;
        logic [13:0] y;     // calendar year, for the leap rule
        logic [13:0] yp;    // year shifted for Jan/Feb
        logic [7:0]  qy;    // y / 100
        logic [7:0]  qp;    // yp / 100
        logic [3:0]  mp;    // month shifted, 3..14
    } nwm_s1_t;

    typedef struct packed {
        nwm_ctl_t    ctl;
        logic [10:0] sum;
        logic [4:0]  dim;
    } nwm_s2_t;

    typedef struct packed {
        nwm_ctl_t    ctl;
        logic [2:0]  wday;  // 0 = Sunday
        logic [4:0]  dim;
    } nwm_s3_t;

    // floor(13 * (mp + 1) / 5)
    function automatic logic [5:0] month_term(input logic [3:0] mp);
        logic [5:0] t;
        unique case (mp)
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            4'd13:   t = 6'd36;
            4'd14:   t = 6'd39;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mp, input logic leap);
        logic [4:0] n;
        unique case (mp)
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            4'd14:                   n = leap ? 5'd29 : 5'd28;
            default:                 n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// ===== sv/nth_weekday_of_month.sv =====
// Throughput: one transaction per cycle; busy is held low. Each transaction passes
//   in order through the four register stages (decode and /100, Zeller sum, mod 7, day select).
// The receiver cannot stall; every result is presented on done for one cycle.
// Reset (rst_n low, asynchronous) clears all stage valid bits and done.
module nth_weekday_of_month (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [2:0]  target_weekday,
    input  logic [2:0]  kind,
    output logic        done,
    output logic [4:0]  day_of_month,
    output logic [1:0]  status
);
    import nwm_pkg::*;

    logic        v1;
    logic        v2;
    logic        v3;
    nwm_s1_t     s1;
    nwm_s2_t     s2;
    nwm_s3_t     s3;

    logic        done_reg;
    logic [4:0]  day_reg;
    logic [4:0]  day_next;
    nwm_status_t status_reg;
    logic [3:0]  off_fwd_raw;
    logic [3:0]  off_bwd_raw;
    logic [3:0]  off_fwd;
    logic [3:0]  off_bwd;

    assign busy = 1'b0;

    nwm_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start & ~busy),
        .year           (year),
        .month          (month),
        .target_weekday (target_weekday),
        .kind           (kind),
        .out_valid      (v1),
        .out            (s1)
    );

    nwm_sum u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v1),
        .in        (s1),
        .out_valid (v2),
        .out       (s2)
    );

    nwm_mod7 u_mod7 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2),
        .in        (s2),
        .out_valid (v3),
        .out       (s3)
    );

    always_comb
    begin
        off_fwd_raw = 4'(s3.ctl.want) + 4'd7 - 4'(s3.wday);
        off_bwd_raw = 4'(s3.wday) + 4'd7 - 4'(s3.ctl.want);
        off_fwd = (off_fwd_raw >= 4'd7) ? off_fwd_raw - 4'd7 : off_fwd_raw;
        off_bwd = (off_bwd_raw >= 4'd7) ? off_bwd_raw - 4'd7 : off_bwd_raw;
        if (s3.ctl.status != ST_OK)
            day_next = 5'd0;
        else
        begin
            case (s3.ctl.kind)
                KIND_TEENTH: day_next = 5'd13 + 5'(off_fwd);
                KIND_LAST:   day_next = s3.dim - 5'(off_bwd);
                default:     day_next = 5'd1 + 5'(off_fwd)
                                      + 5'(s3.ctl.kind - KIND_FIRST) * 5'd7;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3;
    end

    always_ff @(posedge clk)
    begin
        if (v3)
        begin
            day_reg    <= day_next;
            status_reg <= s3.ctl.status;
        end
    end

    assign done         = done_reg;
    assign day_of_month = day_reg;
    assign status       = status_reg;

`ifndef NO_ASSERTIONS
    a_err_day_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> day_of_month == 5'd0)
        else $error("error status with non-zero day");

    a_ok_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_OK |-> day_of_month != 5'd0)
        else $error("ok status with day zero");

    a_teenth_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3 && s3.ctl.status == ST_OK && s3.ctl.kind == KIND_TEENTH
        |=> done && day_of_month >= 5'd13 && day_of_month <= 5'd19)
        else $error("teenth result outside 13..19");

    a_first_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3 && s3.ctl.status == ST_OK && s3.ctl.kind == KIND_FIRST
        |=> done && day_of_month >= 5'd1 && day_of_month <= 5'd7)
        else $error("first-week result outside 1..7");
`endif

endmodule

// ===== sv/nwm_decode.sv =====
module nwm_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [13:0]       year,
    input  logic [3:0]        month,
    input  logic [2:0]        target_weekday,
    input  logic [2:0]        kind,
    output logic              out_valid,
    output nwm_pkg::nwm_s1_t  out
);
    import nwm_pkg::*;

    logic        valid_reg;
    nwm_s1_t     s1_reg;
    nwm_s1_t     s1_next;
    logic        early;
    logic [26:0] prod_y;
    logic [26:0] prod_p;

    always_comb
    begin
        early = (month < 4'd3);
        s1_next.y  = year;
        s1_next.yp = early ? year - 14'd1 : year;
        s1_next.mp = early ? month + 4'd12 : month;
        prod_y = 27'(year) * 27'(DIV100_MUL);
        prod_p = 27'(s1_next.yp) * 27'(DIV100_MUL);
        s1_next.qy = prod_y[DIV100_SHIFT +: 8];
        s1_next.qp = prod_p[DIV100_SHIFT +: 8];
        s1_next.ctl.want = target_weekday;
        s1_next.ctl.kind = kind;
        // bad month wins over bad year
        if (month < 4'd1 || month > 4'd12)
            s1_next.ctl.status = ST_BAD_MONTH;
        else if (year < YEAR_MIN || year > YEAR_MAX)
            s1_next.ctl.status = ST_BAD_YEAR;
        else if (target_weekday > WEEKDAY_MAX || kind > KIND_LAST)
            s1_next.ctl.status = ST_NO_MATCH;
        else
            s1_next.ctl.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            s1_reg <= s1_next;
    end

    assign out_valid = valid_reg;
    assign out       = s1_reg;

endmodule

// ===== sv/nwm_sum.sv =====
module nwm_sum (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  nwm_pkg::nwm_s1_t  in,
    output logic              out_valid,
    output nwm_pkg::nwm_s2_t  out
);
    import nwm_pkg::*;

    logic        valid_reg;
    nwm_s2_t     s2_reg;
    nwm_s2_t     s2_next;
    logic [13:0] hund_p;
    logic [13:0] hund_y;
    logic [6:0]  k;
    logic [6:0]  ry;
    logic        leap;
    logic [4:0]  dim;
    logic [4:0]  day_ref;

    always_comb
    begin
        hund_p = 14'({6'd0, in.qp} * 14'd100);
        hund_y = 14'({6'd0, in.qy} * 14'd100);
        k      = 7'(in.yp - hund_p);
        ry     = 7'(in.y - hund_y);
        leap   = (in.y[1:0] == 2'd0 && ry != 7'd0) || (ry == 7'd0 && in.qy[1:0] == 2'd0);
        dim    = month_len(in.mp, leap);
        // reference day whose weekday is wanted
        case (in.ctl.kind)
            KIND_TEENTH: day_ref = 5'd13;
            KIND_LAST:   day_ref = dim;
            default:     day_ref = 5'd1;
        endcase
        s2_next.ctl = in.ctl;
        s2_next.dim = dim;
        s2_next.sum = 11'(day_ref) + 11'(month_term(in.mp)) + 11'(k) + 11'(k >> 2)
                    + 11'(in.qp >> 2) + 11'(in.qp) * 11'd5;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            s2_reg <= s2_next;
    end

    assign out_valid = valid_reg;
    assign out       = s2_reg;

endmodule

// ===== sv/nwm_mod7.sv =====
module nwm_mod7 (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  nwm_pkg::nwm_s2_t  in,
    output logic              out_valid,
    output nwm_pkg::nwm_s3_t  out
);
    import nwm_pkg::*;

    logic        valid_reg;
    nwm_s3_t     s3_reg;
    nwm_s3_t     s3_next;
    logic [24:0] prod;
    logic [8:0]  q7;
    logic [2:0]  h;

    always_comb
    begin
        prod = 25'(in.sum) * 25'(DIV7_MUL);
        q7   = prod[DIV7_SHIFT +: 9];
        h    = 3'(in.sum - 11'({2'd0, q7} * 11'd7));
        s3_next.ctl  = in.ctl;
        s3_next.dim  = in.dim;
        // congruence gives 0 = Saturday; rotate to 0 = Sunday
        s3_next.wday = (h == 3'd0) ? 3'd6 : h - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            s3_reg <= s3_next;
    end

    assign out_valid = valid_reg;
    assign out       = s3_reg;

endmodule
